/* rtl/lnwq_pkg.sv */
// ============================================================================
// lnwq_pkg: shared types and constants for the LCD nibble write queue
// Queue sizing, field widths, the codes carried in tuser, and the helper that
// builds each port word.
// ============================================================================
package lnwq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int WORD_W      = 7;
    localparam int BYTE_W      = 8;
    localparam int OUT_BITS    = WORD_W + 2 + FILL_W;
    localparam int M_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;
    localparam int STEP_W      = 3;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [STEP_W-1:0] FIRST_STEP = 3'd0;
    localparam logic [STEP_W-1:0] LAST_STEP  = 3'd6;

    localparam logic [WORD_W-1:0] EN_BIT = 7'h40;

    // per-cell control
    typedef struct packed {
        logic push;
        logic pop;
    } lnwq_cell_ctl_t;

    // work handed to the output sequencer
    typedef struct packed {
        logic              valid;
        logic              is_byte;
        logic              dropped;
        logic [FILL_W-1:0] fill;
        logic [BYTE_W-1:0] data;
    } lnwq_job_t;

    // Port word for one step of a byte transfer: high nibble strobed, low
    // nibble strobed, then zero. RS is set for character data (bit 7 clear).
    function automatic logic [WORD_W-1:0] lnwq_word(input logic [BYTE_W-1:0] b,
                                                   input logic [STEP_W-1:0] step);
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] w;
        hi = {2'b00, ~b[7], b[7:4]};
        lo = {2'b00, ~b[7], b[3:0]};
        unique case (step) inside
            3'd0, 3'd2: w = hi;
            3'd1:       w = hi | EN_BIT;
            3'd3, 3'd5: w = lo;
            3'd4:       w = lo | EN_BIT;
            default:    w = '0;
        endcase
        return w;
    endfunction

endpackage

/* rtl/lnwq_cell.sv */
// ============================================================================
// lnwq_cell: one byte slot of the shifting queue
// Loads a new byte when selected for a push, takes its upstream neighbor's
// byte when the queue pops.
// ============================================================================
module lnwq_cell (
    input  logic                   aclk,
    input  lnwq_pkg::lnwq_cell_ctl_t ctl,
    input  logic [7:0]             load_byte,
    input  logic [7:0]             shift_byte,
    output logic [7:0]             cell_byte
);
    import lnwq_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    always_comb begin
        byte_next = byte_reg;
        if (ctl.pop) begin
            byte_next = shift_byte;
        end else if (ctl.push) begin
            byte_next = load_byte;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign cell_byte = byte_reg;

endmodule

/* rtl/lnwq_seq.sv */
// ============================================================================
// lnwq_seq: output sequencer
// Holds the result register and steps through the seven port words of a
// popped byte, one per transfer.
// ============================================================================
module lnwq_seq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lnwq_pkg::lnwq_job_t           job,
    output logic                          job_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lnwq_pkg::WORD_W-1:0]   out_word,
    output logic                          out_write,
    output logic                          out_drop,
    output logic [lnwq_pkg::FILL_W-1:0]   out_fill,
    output logic                          out_last
);
    import lnwq_pkg::*;

    logic              valid_reg,  valid_next;
    logic [WORD_W-1:0] word_reg,   word_next;
    logic              write_reg,  write_next;
    logic              drop_reg,   drop_next;
    logic [FILL_W-1:0] fill_reg,   fill_next;
    logic              last_reg,   last_next;
    logic [STEP_W-1:0] step_reg,   step_next;
    logic [BYTE_W-1:0] byte_reg,   byte_next;
    logic              take;

    assign take      = valid_reg && out_ready;
    assign job_ready = !valid_reg || (out_ready && last_reg);

    always_comb begin
        valid_next = valid_reg;
        word_next  = word_reg;
        write_next = write_reg;
        drop_next  = drop_reg;
        fill_next  = fill_reg;
        last_next  = last_reg;
        step_next  = step_reg;
        byte_next  = byte_reg;
        if (job.valid) begin
            valid_next = 1'b1;
            fill_next  = job.fill;
            drop_next  = job.dropped;
            byte_next  = job.data;
            step_next  = FIRST_STEP;
            if (job.is_byte) begin
                word_next  = lnwq_word(job.data, FIRST_STEP);
                write_next = 1'b1;
                last_next  = 1'b0;
            end else begin
                word_next  = '0;
                write_next = 1'b0;
                last_next  = 1'b1;
            end
        end else if (take) begin
            if (last_reg) begin
                valid_next = 1'b0;
            end else begin
                step_next = step_reg + 1'b1;
                word_next = lnwq_word(byte_reg, step_next);
                last_next = (step_next == LAST_STEP);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg  <= word_next;
        write_reg <= write_next;
        drop_reg  <= drop_next;
        fill_reg  <= fill_next;
        step_reg  <= step_next;
        byte_reg  <= byte_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;
    assign out_write = write_reg;
    assign out_drop  = drop_reg;
    assign out_fill  = fill_reg;
    assign out_last  = last_reg;

endmodule

/* rtl/lcd_nibble_write_queue.sv */
// ============================================================================
// lcd_nibble_write_queue: byte queue feeding a 4-bit character-LCD port
// Output: the first result of an item is registered in the output register in the
//   cycle after its transfer is accepted.
// Throughput: enqueue and idle dequeue give one result; a dequeue gives seven,
//   one per cycle while m_tready is high (counted by the output sequencer's
//   step counter). The next item is accepted in the cycle the previous item's
//   last result is taken.
// Reset: aresetn low for one clock empties the queue and drops any pending
//   result; the byte cells keep stale data, which is never read.
// ============================================================================
module lcd_nibble_write_queue (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,  // [7:0] data_byte
    input  logic                             s_tuser,  // [0] opcode
    // result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [6:0] port_word, [7] port_write, [8] dropped, [FILL_W+8:9] fill_level
    output logic [lnwq_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tlast   // last
);
    import lnwq_pkg::*;

    logic [FILL_W-1:0] count_reg, count_next;
    logic              accept;
    logic              full, empty;
    logic              push, pop, drop;
    lnwq_job_t         job;

    logic [BYTE_W-1:0] cell_data [QUEUE_DEPTH];

    logic [WORD_W-1:0] out_word;
    logic              out_write;
    logic              out_drop;
    logic [FILL_W-1:0] out_fill;

    // ---- input handshake and queue bookkeeping ----
    assign accept = s_tvalid && s_tready;
    assign full   = (count_reg == FILL_W'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign push   = accept && (s_tuser == OP_ENQ) && !full;
    assign pop    = accept && (s_tuser == OP_DEQ) && !empty;
    assign drop   = accept && (s_tuser == OP_ENQ) && full;

    always_comb begin
        count_next = count_reg;
        if (push) begin
            count_next = count_reg + 1'b1;
        end else if (pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // ---- cell chain: cell 0 is the head, a pop shifts everything down ----
    // A push lands in the cell just past the last held byte.
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        lnwq_cell_ctl_t ctl;
        logic [BYTE_W-1:0] upstream;

        assign ctl.push = push && (count_reg == FILL_W'(i));
        assign ctl.pop  = pop;

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign upstream = cell_data[i];
        end else begin : g_mid
            assign upstream = cell_data[i+1];
        end

        lnwq_cell u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .load_byte  (s_tdata),
            .shift_byte (upstream),
            .cell_byte  (cell_data[i])
        );
    end

    // ---- hand the item to the output sequencer ----
    // Idle dequeue and enqueue results both come out as a single word of zero.
    assign job.valid   = accept;
    assign job.is_byte = pop;
    assign job.dropped = drop;
    assign job.fill    = count_next;
    assign job.data    = cell_data[0];

    lnwq_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job       (job),
        .job_ready (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word),
        .out_write (out_write),
        .out_drop  (out_drop),
        .out_fill  (out_fill),
        .out_last  (m_tlast)
    );

    assign m_tdata = M_TDATA_W'({out_fill, out_drop, out_write, out_word});

    // ---- checks ----
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FILL_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_no_accept_mid_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("input accepted during a port word burst");

    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not lower count");

    a_burst_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && out_write))
        else $error("port word burst broke off");

    a_drop_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_drop) |-> (out_fill == FILL_W'(QUEUE_DEPTH)))
        else $error("drop flagged with queue not full");

endmodule

/* bench/lcd_nibble_write_queue_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// lcd_nibble_write_queue_tb: self-checking bench for the LCD nibble queue
// A short table of directed transfers runs first: empty pops, extreme bytes,
// data and command bytes, and dequeue with junk data. Random runs follow:
// fill-to-full with overflow, enqueue runs, dequeue runs, drains past empty,
// and mixed noise. A behavioral queue predicts every port word. The sender
// uses bursts with random gaps, and the receiver switches between its own stall modes.
// ============================================================================
module lcd_nibble_write_queue_tb;

    import lnwq_pkg::*;

    localparam int RANDOM_ITEMS   = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int N_DIRECTED     = 17;

    // m_tdata layout
    localparam int WORD_LSB  = 0;
    localparam int WRITE_BIT = 7;
    localparam int DROP_BIT  = 8;
    localparam int FILL_LSB  = 9;

    localparam logic [WORD_W-1:0] RS_MASK = 7'h10;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              port_write;
        logic              drop;
        logic [FILL_W-1:0] fill;
        logic              last;
    } port_beat_t;

    // one directed transfer; typed rows carry the fill level of their
    // single non-writing result
    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] data;
        logic              typed;
        logic [FILL_W-1:0] fill;
    } dir_row_t;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_COIN,
        RX_SPARSE,
        RX_HOLD
    } rx_mode_t;

    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        '{OP_DEQ, 8'h00, 1'b1, 6'd0},   // pop on empty after reset
        '{OP_ENQ, 8'h00, 1'b1, 6'd1},
        '{OP_ENQ, 8'hFF, 1'b1, 6'd2},
        '{OP_ENQ, 8'h7F, 1'b1, 6'd3},   // largest data byte
        '{OP_ENQ, 8'h80, 1'b1, 6'd4},   // smallest command byte
        '{OP_ENQ, 8'h5A, 1'b1, 6'd5},
        '{OP_DEQ, 8'hFF, 1'b0, 6'd0},   // data field ignored on pops
        '{OP_DEQ, 8'h00, 1'b0, 6'd0},
        '{OP_DEQ, 8'hA5, 1'b0, 6'd0},
        '{OP_DEQ, 8'h00, 1'b0, 6'd0},
        '{OP_DEQ, 8'h00, 1'b0, 6'd0},
        '{OP_DEQ, 8'h00, 1'b1, 6'd0},   // drained: idle again
        '{OP_ENQ, 8'h0F, 1'b1, 6'd1},
        '{OP_ENQ, 8'hF0, 1'b1, 6'd2},
        '{OP_DEQ, 8'h00, 1'b0, 6'd0},
        '{OP_DEQ, 8'hFF, 1'b0, 6'd0},
        '{OP_DEQ, 8'hFF, 1'b1, 6'd0}
    };

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata  = 8'h00;
    logic                 s_tuser  = OP_ENQ;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    logic [BYTE_W-1:0] held_bytes [$];     // predicted queue contents
    port_beat_t        port_words_due [$]; // results still to arrive
    int                mismatches  = 0;
    int                burst_left  = 0;
    int                idle_cycles = 0;
    rx_mode_t          rx_mode     = RX_STEADY;
    int                rx_left     = 0;

    lcd_nibble_write_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Work out the port words one accepted transfer causes.
    task automatic predict_port_words(input logic op, input logic [BYTE_W-1:0] data);
        port_beat_t        beat;
        logic [BYTE_W-1:0] b;
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] lo;
        beat      = '0;
        beat.last = 1'b1;
        if (op == OP_ENQ) begin
            if (held_bytes.size() >= QUEUE_DEPTH) begin
                beat.drop = 1'b1;              // full: byte thrown away
            end else begin
                held_bytes.push_back(data);
            end
            beat.fill = FILL_W'(held_bytes.size());
            port_words_due.push_back(beat);
        end else if (held_bytes.size() == 0) begin
            port_words_due.push_back(beat);    // idle status
        end else begin
            b  = held_bytes.pop_front();
            hi = {3'b000, b[7:4]};
            if (!b[7]) begin
                hi = hi | RS_MASK;             // character data
            end
            lo = {hi[6:4], b[3:0]};
            beat.port_write = 1'b1;
            beat.fill       = FILL_W'(held_bytes.size());
            for (int k = 0; k < 7; k++) begin
                case (k)
                    0, 2:    beat.word = hi;
                    1:       beat.word = hi | EN_BIT;
                    3, 5:    beat.word = lo;
                    4:       beat.word = lo | EN_BIT;
                    default: beat.word = '0;
                endcase
                beat.last = (k == 6);
                port_words_due.push_back(beat);
            end
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic op, input logic [BYTE_W-1:0] data,
                             input logic typed, input logic [FILL_W-1:0] fill);
        int         gap;
        port_beat_t beat;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 10);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_port_words(op, data);
        if (typed) begin
            // hand-written expectation stands in for the predicted one
            beat = '{word: '0, port_write: 1'b0, drop: 1'b0, fill: fill, last: 1'b1};
            void'(port_words_due.pop_back());
            port_words_due.push_back(beat);
        end
        burst_left--;
        @(negedge aclk);
    endtask

    // Receiver: stretches of steady, coin-flip, sparse or held-off ready.
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(8, 64);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_STEADY: m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:   m_tready <= 1'b0;
        endcase
    end

    // Result checker
    always @(posedge aclk) begin
        port_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (port_words_due.size() == 0) begin
                $error("unexpected result transfer: m_tdata %0h", m_tdata);
                mismatches = mismatches + 1;
            end else begin
                want = port_words_due.pop_front();
                if (m_tdata[WORD_LSB +: WORD_W] !== want.word) begin
                    $error("port_word: expected %0h, actual %0h",
                           want.word, m_tdata[WORD_LSB +: WORD_W]);
                    mismatches = mismatches + 1;
                end
                if (m_tdata[WRITE_BIT] !== want.port_write) begin
                    $error("port_write: expected %0d, actual %0d",
                           want.port_write, m_tdata[WRITE_BIT]);
                    mismatches = mismatches + 1;
                end
                if (m_tdata[DROP_BIT] !== want.drop) begin
                    $error("dropped: expected %0d, actual %0d",
                           want.drop, m_tdata[DROP_BIT]);
                    mismatches = mismatches + 1;
                end
                if (m_tdata[FILL_LSB +: FILL_W] !== want.fill) begin
                    $error("fill_level: expected %0d, actual %0d",
                           want.fill, m_tdata[FILL_LSB +: FILL_W]);
                    mismatches = mismatches + 1;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, m_tlast);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        int sent;
        int mode;
        int k;
        sent = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_item(DIRECTED[i].op, DIRECTED[i].data, DIRECTED[i].typed,
                      DIRECTED[i].fill);
        end

        while (sent < RANDOM_ITEMS) begin
            mode = $urandom_range(0, 9);
            case (mode)
                0: begin
                    // fill to the brim, then overflow a few times
                    k = QUEUE_DEPTH - held_bytes.size() + $urandom_range(1, 3);
                    repeat (k) send_item(OP_ENQ, 8'($urandom_range(0, 255)), 1'b0, '0);
                end
                1, 2, 3: begin
                    k = $urandom_range(1, 10);
                    repeat (k) send_item(OP_ENQ, 8'($urandom_range(0, 255)), 1'b0, '0);
                end
                4, 5, 6: begin
                    k = $urandom_range(1, 8);
                    repeat (k) send_item(OP_DEQ, 8'($urandom_range(0, 255)), 1'b0, '0);
                end
                7: begin
                    // drain and keep popping on empty
                    k = held_bytes.size() + $urandom_range(1, 2);
                    repeat (k) send_item(OP_DEQ, 8'($urandom_range(0, 255)), 1'b0, '0);
                end
                default: begin
                    k = $urandom_range(1, 4);
                    repeat (k) begin
                        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                  1'b0, '0);
                    end
                end
            endcase
            sent += k;
        end
        s_tvalid <= 1'b0;

        while (port_words_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/lnwq_pkg.sv
rtl/lnwq_cell.sv
rtl/lnwq_seq.sv
rtl/lcd_nibble_write_queue.sv
bench/lcd_nibble_write_queue_tb.sv
